/* rtl/rrr_pkg.sv */
package rrr_pkg;

  // Fixed field widths of the request and result words.
  localparam int ARCH_REGS = 32;
  localparam int REG_W     = 5;
  localparam int TAG_W     = 6;
  localparam int SLOT_W    = 5;
  localparam int IDX_W     = 5;

  // Default sizes handed to the top level.
  localparam int DEF_ROB_DEPTH  = 32;
  localparam int DEF_FREE_DEPTH = 32;
  localparam int DEF_PHYS_REGS  = 64;

  typedef enum logic [1:0] {
    REQ_RENAME   = 2'd0,
    REQ_COMPLETE = 2'd1,
    REQ_COMMIT   = 2'd2,
    REQ_FLUSH    = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_ROB_FULL  = 3'd1,
    STAT_NO_FREE   = 3'd2,
    STAT_SER_WAIT  = 3'd3,
    STAT_NOT_DONE  = 3'd4,
    STAT_BAD_ENTRY = 3'd5
  } status_t;

  // A classified request as it waits in the queue between front and back.
  typedef struct packed {
    req_kind_t        kind;
    logic             writes;
    logic [REG_W-1:0] dest_reg;
    logic             src1_live;
    logic [REG_W-1:0] src1_reg;
    logic             src2_live;
    logic [REG_W-1:0] src2_reg;
    logic             serializing;
    logic [IDX_W-1:0] entry_index;
  } op_item_t;

  // One result word.
  typedef struct packed {
    logic              accepted;
    status_t           status;
    logic [SLOT_W-1:0] rob_slot;
    logic [TAG_W-1:0]  dest_phys;
    logic [TAG_W-1:0]  prior_phys;
    logic [TAG_W-1:0]  src1_phys;
    logic              src1_avail;
    logic [TAG_W-1:0]  src2_phys;
    logic              src2_avail;
    logic [REG_W-1:0]  commit_arch_reg;
    logic              commit_writes;
  } result_t;

endpackage

/* rtl/rrr_ifs.sv */
interface rrr_req_if;
  import rrr_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       req_type;
  logic             has_dest;
  logic [REG_W-1:0] dest_reg;
  logic             src1_used;
  logic [REG_W-1:0] src1_reg;
  logic             src2_used;
  logic [REG_W-1:0] src2_reg;
  logic             serializing;
  logic [IDX_W-1:0] entry_index;

  modport source (output valid, req_type, has_dest, dest_reg, src1_used, src1_reg,
                  src2_used, src2_reg, serializing, entry_index, input ready);
  modport sink (input valid, req_type, has_dest, dest_reg, src1_used, src1_reg,
                src2_used, src2_reg, serializing, entry_index, output ready);
endinterface

interface rrr_rsp_if;
  import rrr_pkg::*;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [2:0]        status;
  logic [SLOT_W-1:0] rob_slot;
  logic [TAG_W-1:0]  dest_phys;
  logic [TAG_W-1:0]  prior_phys;
  logic [TAG_W-1:0]  src1_phys;
  logic              src1_avail;
  logic [TAG_W-1:0]  src2_phys;
  logic              src2_avail;
  logic [REG_W-1:0]  commit_arch_reg;
  logic              commit_writes;

  modport source (output valid, accepted, status, rob_slot, dest_phys, prior_phys,
                  src1_phys, src1_avail, src2_phys, src2_avail, commit_arch_reg,
                  commit_writes, input ready);
  modport sink (input valid, accepted, status, rob_slot, dest_phys, prior_phys,
                src1_phys, src1_avail, src2_phys, src2_avail, commit_arch_reg,
                commit_writes, output ready);
endinterface

/* rtl/rrr_front.sv */
module rrr_front (
  input  logic             clk,
  input  logic             rst_n,
  rrr_req_if.sink          in_req,
  output rrr_pkg::op_item_t q_item,
  output logic             q_valid,
  input  logic             q_ready
);
  import rrr_pkg::*;

  op_item_t   q_mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  op_item_t   cls;
  logic       push, pop;

  // Decode the request kind and flag which registers really take part.
  always_comb begin
    cls.kind        = req_kind_t'(in_req.req_type);
    cls.writes      = in_req.has_dest && (in_req.dest_reg != '0);
    cls.dest_reg    = in_req.dest_reg;
    cls.src1_live   = in_req.src1_used && (in_req.src1_reg != '0);
    cls.src1_reg    = in_req.src1_reg;
    cls.src2_live   = in_req.src2_used && (in_req.src2_reg != '0);
    cls.src2_reg    = in_req.src2_reg;
    cls.serializing = in_req.serializing;
    cls.entry_index = in_req.entry_index;
  end

  // Two-entry queue towards the back end.
  assign in_req.ready = (cnt_r != 2'd2);
  assign push    = in_req.valid && in_req.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_item  = q_mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= cls;
    end
  end

endmodule

/* rtl/rrr_back.sv */
module rrr_back #(
  parameter int ROB_DEPTH  = rrr_pkg::DEF_ROB_DEPTH,
  parameter int FREE_DEPTH = rrr_pkg::DEF_FREE_DEPTH,
  parameter int PHYS_REGS  = rrr_pkg::DEF_PHYS_REGS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rrr_pkg::op_item_t q_item,
  input  logic              q_valid,
  output logic              q_ready,
  rrr_rsp_if.source         out_rsp
);
  import rrr_pkg::*;

  localparam int RIW   = $clog2(ROB_DEPTH);
  localparam int RCW   = $clog2(ROB_DEPTH + 1);
  localparam int FIW   = $clog2(FREE_DEPTH);
  localparam int FCW   = $clog2(FREE_DEPTH + 1);
  localparam int PW    = $clog2(PHYS_REGS);
  localparam int NFILL = (PHYS_REGS - ARCH_REGS < FREE_DEPTH) ?
                         (PHYS_REGS - ARCH_REGS) : FREE_DEPTH;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WRD  = 4'b0100,
    S_WUPD = 4'b1000
  } state_t;

  state_t st_r, st_nxt;
  op_item_t cur_r;

  // Rename map: two copies so that both sources and the destination read at once.
  logic [PW-1:0]        map_a_mem [ARCH_REGS];
  logic [PW-1:0]        map_b_mem [ARCH_REGS];
  logic [ARCH_REGS-1:0] map_wr_r, map_wr_nxt;
  logic [PW-1:0]        map_a1_q, map_a2_q, map_b_q;
  logic                 map_we;
  logic [REG_W-1:0]     map_wa;
  logic [PW-1:0]        map_wd;

  // Free ring.
  logic [PW-1:0]         fr_mem [FREE_DEPTH];
  logic [FREE_DEPTH-1:0] fr_wr_r, fr_wr_nxt;
  logic [PW-1:0]         fr_q;
  logic [FIW-1:0]        fr_head_r, fr_head_nxt, fr_tail_r, fr_tail_nxt;
  logic [FCW-1:0]        fr_cnt_r, fr_cnt_nxt;
  logic                  push_en, pop_en, fr_we;
  logic [PW-1:0]         push_val;

  // Reorder buffer.
  logic [REG_W-1:0]     rob_ad_mem [ROB_DEPTH];
  logic [PW-1:0]        rob_np_mem [ROB_DEPTH];
  logic [PW-1:0]        rob_op_mem [ROB_DEPTH];
  logic [REG_W-1:0]     rob_ad_q;
  logic [PW-1:0]        rob_np_q, rob_op_q;
  logic [ROB_DEPTH-1:0] rob_valid_r, rob_valid_nxt, rob_done_r, rob_done_nxt;
  logic [RIW-1:0]       rob_head_r, rob_head_nxt, rob_tail_r, rob_tail_nxt;
  logic [RCW-1:0]       rob_used_r, rob_used_nxt;
  logic                 rob_we;
  logic [RIW-1:0]       rob_ra, tail_dec, idx_w;

  logic [PHYS_REGS-1:0] rdy_r, rdy_nxt;

  // Flush walk.
  logic [RIW-1:0] stop_r, stop_nxt;
  logic [RCW-1:0] guard_r, guard_nxt;
  logic           walk_end;

  // Result register.
  logic    out_valid_r, out_valid_nxt, out_free, out_load;
  result_t out_res_r, res;

  logic           rd_en, idx_ok, writes_ok;
  logic [PW-1:0]  p1, p2;

  assign q_ready  = (st_r == S_IDLE);
  assign out_free = !out_valid_r || out_rsp.ready;
  assign tail_dec = (rob_tail_r == '0) ? RIW'(ROB_DEPTH - 1) : rob_tail_r - 1'b1;
  assign idx_w    = RIW'(cur_r.entry_index);
  assign idx_ok   = (32'(cur_r.entry_index) < 32'(ROB_DEPTH)) && rob_valid_r[idx_w];
  assign walk_end = (rob_tail_r == stop_r) || (guard_r == RCW'(ROB_DEPTH));
  assign rd_en    = ((st_r == S_IDLE) && q_valid) || ((st_r == S_WRD) && !walk_end);
  assign rob_ra   = (st_r != S_IDLE) ? tail_dec :
                    (q_item.kind == REQ_COMPLETE) ? RIW'(q_item.entry_index) : rob_head_r;
  assign p1       = cur_r.src1_live ? map_a1_q : '0;
  assign p2       = cur_r.src2_live ? map_a2_q : '0;

  // Sequencer: each request executes once its reads are back and the result register is free; flush walks back.
  always_comb begin
    st_nxt        = st_r;
    map_wr_nxt    = map_wr_r;
    fr_wr_nxt     = fr_wr_r;
    fr_head_nxt   = fr_head_r;
    fr_tail_nxt   = fr_tail_r;
    fr_cnt_nxt    = fr_cnt_r;
    rob_valid_nxt = rob_valid_r;
    rob_done_nxt  = rob_done_r;
    rob_head_nxt  = rob_head_r;
    rob_tail_nxt  = rob_tail_r;
    rob_used_nxt  = rob_used_r;
    rdy_nxt       = rdy_r;
    stop_nxt      = stop_r;
    guard_nxt     = guard_r;
    map_we        = 1'b0;
    map_wa        = cur_r.dest_reg;
    map_wd        = fr_q;
    push_en       = 1'b0;
    push_val      = rob_op_q;
    pop_en        = 1'b0;
    rob_we        = 1'b0;
    out_load      = 1'b0;
    res           = '0;
    writes_ok     = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          st_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          st_nxt   = S_IDLE;
          out_load = 1'b1;
          case (cur_r.kind)
            REQ_RENAME: begin
              if (cur_r.serializing && rob_used_r != '0) begin
                res.status = STAT_SER_WAIT;
              end else if (rob_used_r == RCW'(ROB_DEPTH)) begin
                res.status = STAT_ROB_FULL;
              end else if (cur_r.writes && fr_cnt_r == '0) begin
                res.status = STAT_NO_FREE;
              end else begin
                writes_ok      = cur_r.writes;
                res.accepted   = 1'b1;
                res.rob_slot   = SLOT_W'(rob_tail_r);
                res.src1_phys  = TAG_W'(p1);
                res.src1_avail = (32'(p1) < 32'(PHYS_REGS)) ? rdy_r[p1] : 1'b1;
                res.src2_phys  = TAG_W'(p2);
                res.src2_avail = (32'(p2) < 32'(PHYS_REGS)) ? rdy_r[p2] : 1'b1;
                if (writes_ok) begin
                  res.dest_phys  = TAG_W'(fr_q);
                  res.prior_phys = TAG_W'(map_b_q);
                  pop_en         = 1'b1;
                  map_we         = 1'b1;
                  if (32'(fr_q) < 32'(PHYS_REGS)) begin
                    rdy_nxt[fr_q] = 1'b0;
                  end
                end
                rob_we                    = 1'b1;
                rob_valid_nxt[rob_tail_r] = 1'b1;
                rob_done_nxt[rob_tail_r]  = 1'b0;
                rob_tail_nxt = (rob_tail_r == RIW'(ROB_DEPTH - 1)) ? '0 : rob_tail_r + 1'b1;
                rob_used_nxt = rob_used_r + 1'b1;
              end
            end
            REQ_COMPLETE: begin
              if (!idx_ok) begin
                res.status = STAT_BAD_ENTRY;
              end else begin
                res.accepted        = 1'b1;
                rob_done_nxt[idx_w] = 1'b1;
                if (32'(rob_np_q) < 32'(PHYS_REGS)) begin
                  rdy_nxt[rob_np_q] = 1'b1;
                end
              end
            end
            REQ_COMMIT: begin
              if (rob_used_r == '0 || !rob_valid_r[rob_head_r]) begin
                res.status = STAT_BAD_ENTRY;
              end else if (!rob_done_r[rob_head_r]) begin
                res.status = STAT_NOT_DONE;
              end else begin
                res.accepted  = 1'b1;
                res.rob_slot  = SLOT_W'(rob_head_r);
                res.dest_phys = TAG_W'(rob_np_q);
                if (rob_ad_q != '0) begin
                  push_en             = 1'b1;
                  res.prior_phys      = TAG_W'(rob_op_q);
                  res.commit_arch_reg = rob_ad_q;
                  res.commit_writes   = 1'b1;
                end
                rob_valid_nxt[rob_head_r] = 1'b0;
                rob_done_nxt[rob_head_r]  = 1'b0;
                rob_head_nxt = (rob_head_r == RIW'(ROB_DEPTH - 1)) ? '0 : rob_head_r + 1'b1;
                rob_used_nxt = rob_used_r - 1'b1;
              end
            end
            REQ_FLUSH: begin
              if (!idx_ok) begin
                res.status = STAT_BAD_ENTRY;
              end else begin
                // The answer goes out when the walk has finished.
                out_load  = 1'b0;
                st_nxt    = S_WRD;
                stop_nxt  = (idx_w == RIW'(ROB_DEPTH - 1)) ? '0 : idx_w + 1'b1;
                guard_nxt = '0;
              end
            end
            default: begin
              res.status = STAT_BAD_ENTRY;
            end
          endcase
        end
      end
      S_WRD: begin
        if (walk_end) begin
          if (out_free) begin
            out_load     = 1'b1;
            res.accepted = 1'b1;
            st_nxt       = S_IDLE;
          end
        end else begin
          rob_tail_nxt = tail_dec;
          guard_nxt    = guard_r + 1'b1;
          st_nxt       = S_WUPD;
        end
      end
      S_WUPD: begin
        // Undo one entry: restore the old mapping and return the new register.
        if (rob_valid_r[rob_tail_r]) begin
          if (rob_ad_q != '0) begin
            map_we   = 1'b1;
            map_wa   = rob_ad_q;
            map_wd   = rob_op_q;
            push_en  = 1'b1;
            push_val = rob_np_q;
          end
          rob_valid_nxt[rob_tail_r] = 1'b0;
          rob_done_nxt[rob_tail_r]  = 1'b0;
          if (rob_used_r != '0) begin
            rob_used_nxt = rob_used_r - 1'b1;
          end
        end
        st_nxt = S_WRD;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase

    if (map_we) begin
      map_wr_nxt[map_wa] = 1'b1;
    end

    // Free ring bookkeeping; a push onto a full ring is dropped.
    fr_we = push_en && (fr_cnt_r < FCW'(FREE_DEPTH));
    if (fr_we) begin
      fr_wr_nxt[fr_tail_r] = 1'b1;
      fr_tail_nxt = (fr_tail_r == FIW'(FREE_DEPTH - 1)) ? '0 : fr_tail_r + 1'b1;
      fr_cnt_nxt  = fr_cnt_r + 1'b1;
    end
    if (pop_en) begin
      fr_head_nxt = (fr_head_r == FIW'(FREE_DEPTH - 1)) ? '0 : fr_head_r + 1'b1;
      fr_cnt_nxt  = fr_cnt_r - 1'b1;
    end

    out_valid_nxt = out_load ? 1'b1 : (out_rsp.ready ? 1'b0 : out_valid_r);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      map_wr_r    <= '0;
      fr_wr_r     <= '0;
      fr_head_r   <= '0;
      fr_tail_r   <= FIW'(NFILL % FREE_DEPTH);
      fr_cnt_r    <= FCW'(NFILL);
      rob_valid_r <= '0;
      rob_done_r  <= '0;
      rob_head_r  <= '0;
      rob_tail_r  <= '0;
      rob_used_r  <= '0;
      rdy_r       <= '1;
      stop_r      <= '0;
      guard_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      map_wr_r    <= map_wr_nxt;
      fr_wr_r     <= fr_wr_nxt;
      fr_head_r   <= fr_head_nxt;
      fr_tail_r   <= fr_tail_nxt;
      fr_cnt_r    <= fr_cnt_nxt;
      rob_valid_r <= rob_valid_nxt;
      rob_done_r  <= rob_done_nxt;
      rob_head_r  <= rob_head_nxt;
      rob_tail_r  <= rob_tail_nxt;
      rob_used_r  <= rob_used_nxt;
      rdy_r       <= rdy_nxt;
      stop_r      <= stop_nxt;
      guard_r     <= guard_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers and the request held during execution.
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && q_valid) begin
      cur_r <= q_item;
    end
    if (out_load) begin
      out_res_r <= res;
    end
  end

  // Memory writes.
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_a_mem[map_wa] <= map_wd;
      map_b_mem[map_wa] <= map_wd;
    end
    if (fr_we) begin
      fr_mem[fr_tail_r] <= push_val;
    end
    if (rob_we) begin
      rob_ad_mem[rob_tail_r] <= writes_ok ? cur_r.dest_reg : '0;
      rob_np_mem[rob_tail_r] <= writes_ok ? fr_q : '0;
      rob_op_mem[rob_tail_r] <= writes_ok ? map_b_q : '0;
    end
  end

  // Registered memory reads; map and free ring entries never written read as their reset value.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      map_a1_q <= map_wr_r[q_item.src1_reg] ? map_a_mem[q_item.src1_reg] :
                  PW'(q_item.src1_reg);
      map_a2_q <= map_wr_r[q_item.src2_reg] ? map_a_mem[q_item.src2_reg] :
                  PW'(q_item.src2_reg);
      map_b_q  <= map_wr_r[q_item.dest_reg] ? map_b_mem[q_item.dest_reg] :
                  PW'(q_item.dest_reg);
      fr_q     <= fr_wr_r[fr_head_r] ? fr_mem[fr_head_r] :
                  PW'(ARCH_REGS) + PW'(fr_head_r);
      rob_ad_q <= rob_ad_mem[rob_ra];
      rob_np_q <= rob_np_mem[rob_ra];
      rob_op_q <= rob_op_mem[rob_ra];
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.accepted        = out_res_r.accepted;
  assign out_rsp.status          = out_res_r.status;
  assign out_rsp.rob_slot        = out_res_r.rob_slot;
  assign out_rsp.dest_phys       = out_res_r.dest_phys;
  assign out_rsp.prior_phys      = out_res_r.prior_phys;
  assign out_rsp.src1_phys       = out_res_r.src1_phys;
  assign out_rsp.src1_avail      = out_res_r.src1_avail;
  assign out_rsp.src2_phys       = out_res_r.src2_phys;
  assign out_rsp.src2_avail      = out_res_r.src2_avail;
  assign out_rsp.commit_arch_reg = out_res_r.commit_arch_reg;
  assign out_rsp.commit_writes   = out_res_r.commit_writes;

  // An empty reorder buffer has its pointers together.
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (rob_used_r == '0) |-> (rob_head_r == rob_tail_r))
    else $error("reorder buffer empty but head and tail differ");

  // While anything is outstanding the head entry is live.
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (rob_used_r != '0) |-> rob_valid_r[rob_head_r])
    else $error("head entry not valid with entries outstanding");

  // Undoing an entry never grows the occupancy.
  a_walk_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_WUPD) |=> (rob_used_r <= $past(rob_used_r)))
    else $error("flush walk increased occupancy");

  // The free count never passes the ring size.
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fr_cnt_r <= FCW'(FREE_DEPTH))
    else $error("free count beyond ring size");

endmodule

/* rtl/register_rename_rob_unit_top.sv */
// Channel   Direction  Word
// in_req    in         one request: rename, complete, commit or flush
// out_rsp   out        one result word per request
//
// Rename, complete and commit in the back end first read the map, free ring and
// reorder buffer memories, then execute and load the result.
// A flush walks back one entry per read and update pair, then sees the end of the
// walk and loads the result.
// A two-word queue lets the front accept while the back works.
// Synchronous active-low reset; no clearing pass, the state is usable at once.
// The result register holds a word until taken; the back end waits for it.
module register_rename_rob_unit_top #(
  parameter int ROB_DEPTH  = rrr_pkg::DEF_ROB_DEPTH,
  parameter int FREE_DEPTH = rrr_pkg::DEF_FREE_DEPTH,
  parameter int PHYS_REGS  = rrr_pkg::DEF_PHYS_REGS
) (
  input logic       clk,
  input logic       rst_n,
  rrr_req_if.sink   in_req,
  rrr_rsp_if.source out_rsp
);
  import rrr_pkg::*;

  op_item_t q_item;
  logic     q_valid;
  logic     q_ready;

  // Front: classify and queue.
  rrr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  // Back: rename tables, reorder buffer and result register.
  rrr_back #(
    .ROB_DEPTH  (ROB_DEPTH),
    .FREE_DEPTH (FREE_DEPTH),
    .PHYS_REGS  (PHYS_REGS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .out_rsp (out_rsp)
  );

endmodule
